>>> hw/rtl/rco_pkg.sv
// Shared constants, types and control structs of the rod-cutting optimizer.
package rco_pkg;

    localparam int MAX_LEN       = 32;
    localparam int PRICE_BITS    = 16;
    localparam int IN_PRICE_BITS = 16;
    localparam int OUT_LEN_BITS  = 6;
    localparam int OUT_REV_BITS  = 21;

    localparam int IDX_BITS    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_BITS    = $clog2(MAX_LEN + 1);
    localparam int REV_BITS    = PRICE_BITS + $clog2(MAX_LEN);
    localparam int NUM_BANKS   = 2;
    localparam int BANK_BITS   = $clog2(NUM_BANKS);
    localparam int PADDR_BITS  = BANK_BITS + IDX_BITS;
    localparam int PRICE_DEPTH = NUM_BANKS * (1 << IDX_BITS);
    localparam int STORE_DEPTH = MAX_LEN + 1;
    localparam int QCNT_BITS   = $clog2(NUM_BANKS + 1);

    typedef logic [IN_PRICE_BITS-1:0] t_in_price;
    typedef logic [PRICE_BITS-1:0]    t_price;
    typedef logic [IDX_BITS-1:0]      t_idx;
    typedef logic [LEN_BITS-1:0]      t_len;
    typedef logic [REV_BITS-1:0]      t_rev;
    typedef logic [BANK_BITS-1:0]     t_bank;
    typedef logic [PADDR_BITS-1:0]    t_paddr;
    typedef logic [QCNT_BITS-1:0]     t_qcnt;
    typedef logic [OUT_LEN_BITS-1:0]  t_out_len;
    typedef logic [OUT_REV_BITS-1:0]  t_out_rev;

    // Price table write from the loader.
    typedef struct packed {
        logic   we;
        t_paddr addr;
        t_price data;
    } t_price_wr;

    // A finished table handed to the solver queue.
    typedef struct packed {
        logic valid;
        t_len len;
    } t_job_push;

    // Head of the job queue as seen by the solver.
    typedef struct packed {
        logic not_empty;
        t_len len;
    } t_job_head;

    // Solver handshake back toward the queue and the loader.
    typedef struct packed {
        logic pop;
        logic done;
    } t_solver_stat;

endpackage

>>> hw/rtl/rco_in_if.sv
// Input channel: one price per transfer.
interface rco_in_if;
    import rco_pkg::*;

    logic      valid;
    logic      ready;
    t_in_price price;
    logic      last_price;

    modport source (output valid, output price, output last_price, input ready);
    modport sink   (input valid, input price, input last_price, output ready);
endinterface

>>> hw/rtl/rco_out_if.sv
// Output channel: one piece of the optimal cutting per transfer.
interface rco_out_if;
    import rco_pkg::*;

    logic     valid;
    logic     ready;
    t_out_len piece_length;
    t_out_rev best_revenue;
    logic     last_piece;

    modport source (output valid, output piece_length, output best_revenue,
                    output last_piece, input ready);
    modport sink   (input valid, input piece_length, input best_revenue,
                    input last_piece, output ready);
endinterface

>>> hw/rtl/rod_cutting_optimizer_top.sv
// Flow: after the last price of a table is taken, the solver computes the best revenue of each
// length i in turn, one compare per cycle, and then walks the cut table to emit the pieces.
// Each further piece is shown after the previous one is taken and the cut table is read again.
// Throughput: prices load one per cycle while one of the two price banks is free.
// Reset: synchronous, active low; it clears control state with no clearing pass.
// Top level of the rod-cutting optimizer.
module rod_cutting_optimizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rco_in_if.sink    i_in,
    rco_out_if.source o_out
);
    import rco_pkg::*;

    // The loader writes prices into the bank it owns, while the solver reads the other bank.
    // Tables travel between them as lengths through a two-entry queue, so loading of the
    // next table overlaps the recurrence and the output of the current one.
    t_price_wr    w_price_wr;
    t_job_push    w_push;
    t_job_head    w_head;
    t_solver_stat w_stat;
    t_paddr       w_price_raddr;
    t_price       w_price_rdata;

    rco_loader u_loader (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_stat     (w_stat),
        .o_price_wr (w_price_wr),
        .o_push     (w_push)
    );

    // Two banks of prices, one per table in flight.
    rco_ram #(.WIDTH(PRICE_BITS), .DEPTH(PRICE_DEPTH)) u_price_ram (
        .i_clk   (i_clk),
        .i_we    (w_price_wr.we),
        .i_waddr (w_price_wr.addr),
        .i_wdata (w_price_wr.data),
        .i_raddr (w_price_raddr),
        .o_rdata (w_price_rdata)
    );

    rco_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_stat  (w_stat),
        .o_head  (w_head)
    );

    // The solver holds each piece in its output register until the transfer completes.
    rco_solver u_solver (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_price_rdata (w_price_rdata),
        .o_price_raddr (w_price_raddr),
        .o_stat        (w_stat),
        .o_out         (o_out)
    );
endmodule

>>> hw/rtl/rco_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module rco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/rco_loader.sv
// Front end: accepts prices, fills one table bank and hands finished tables on.
module rco_loader (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rco_in_if.sink                i_in,
    input  rco_pkg::t_solver_stat i_stat,
    output rco_pkg::t_price_wr    o_price_wr,
    output rco_pkg::t_job_push    o_push
);
    import rco_pkg::*;

    t_idx  r_cnt;
    t_bank r_wbank;
    t_qcnt r_jobs;
    t_idx  n_cnt;
    t_bank n_wbank;
    t_qcnt n_jobs;
    logic  w_accept;
    t_len  w_len;
    logic  w_end;

    // A bank is free while fewer tables than banks are pushed but not yet finished by the solver.
    assign i_in.ready = (r_jobs < t_qcnt'(NUM_BANKS));
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_len      = t_len'(r_cnt) + t_len'(1);
    assign w_end      = i_in.last_price || (w_len == t_len'(MAX_LEN));

    assign o_price_wr.we   = w_accept;
    assign o_price_wr.addr = {r_wbank, r_cnt};
    assign o_price_wr.data = t_price'(i_in.price);
    assign o_push.valid    = w_accept && w_end;
    assign o_push.len      = w_len;

    always_comb begin
        n_cnt   = r_cnt;
        n_wbank = r_wbank;
        n_jobs  = r_jobs;
        if (w_accept) begin
            if (w_end) begin
                n_cnt   = '0;
                n_wbank = r_wbank + t_bank'(1);
            end else begin
                n_cnt = r_cnt + t_idx'(1);
            end
        end
        if (o_push.valid && !i_stat.done) begin
            n_jobs = r_jobs + t_qcnt'(1);
        end else if (!o_push.valid && i_stat.done) begin
            n_jobs = r_jobs - t_qcnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wbank <= '0;
            r_jobs  <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_wbank <= n_wbank;
            r_jobs  <= n_jobs;
        end
    end

    a_jobs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jobs <= t_qcnt'(NUM_BANKS))
        else $error("more tables outstanding than price banks");
endmodule

>>> hw/rtl/rco_job_queue.sv
// Short queue of table lengths between the loader and the solver.
module rco_job_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rco_pkg::t_job_push    i_push,
    input  rco_pkg::t_solver_stat i_stat,
    output rco_pkg::t_job_head    o_head
);
    import rco_pkg::*;

    t_len  r_mem [NUM_BANKS];
    t_bank r_wp;
    t_bank r_rp;
    t_qcnt r_cnt;

    assign o_head.not_empty = (r_cnt != '0);
    assign o_head.len       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.len;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= r_wp + t_bank'(1);
            end
            if (i_stat.pop) begin
                r_rp <= r_rp + t_bank'(1);
            end
            if (i_push.valid && !i_stat.pop) begin
                r_cnt <= r_cnt + t_qcnt'(1);
            end else if (!i_push.valid && i_stat.pop) begin
                r_cnt <= r_cnt - t_qcnt'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> (r_cnt < t_qcnt'(NUM_BANKS)))
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.pop |-> (r_cnt != '0))
        else $error("job queue read while empty");
endmodule

>>> hw/rtl/rco_solver.sv
// Back end: runs the rod-cutting recurrence and walks the chosen cuts.
module rco_solver (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rco_pkg::t_job_head    i_head,
    input  rco_pkg::t_price       i_price_rdata,
    output rco_pkg::t_paddr       o_price_raddr,
    output rco_pkg::t_solver_stat o_stat,
    rco_out_if.source             o_out
);
    import rco_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_ISSUE, S_WAIT, S_WRITE, S_TREAD, S_TOUT, S_EMIT
    } t_state;

    t_state r_state;
    t_len   r_n;
    t_len   r_i;
    t_len   r_j;
    t_len   r_dj;
    logic   r_dv;
    t_rev   r_best;
    t_len   r_cut;
    t_rev   r_total;
    t_len   r_rest;
    t_len   r_piece;
    logic   r_last;
    logic   r_out_valid;
    t_bank  r_rbank;

    logic   w_rev_we;
    t_len   w_rev_waddr;
    t_rev   w_rev_wdata;
    t_rev   w_rev_rdata;
    t_len   w_cut_rdata;
    t_rev   w_cand;
    t_len   w_cut_fix;

    assign w_rev_we    = (r_state == S_INIT) || (r_state == S_WRITE);
    assign w_rev_waddr = (r_state == S_INIT) ? '0 : r_i;
    assign w_rev_wdata = (r_state == S_INIT) ? '0 : r_best;

    rco_ram #(.WIDTH(REV_BITS), .DEPTH(STORE_DEPTH)) u_rev_ram (
        .i_clk   (i_clk),
        .i_we    (w_rev_we),
        .i_waddr (w_rev_waddr),
        .i_wdata (w_rev_wdata),
        .i_raddr (r_i - r_j),
        .o_rdata (w_rev_rdata)
    );

    rco_ram #(.WIDTH(LEN_BITS), .DEPTH(STORE_DEPTH)) u_cut_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_i),
        .i_wdata (r_cut),
        .i_raddr (r_rest),
        .o_rdata (w_cut_rdata)
    );

    assign o_price_raddr = {r_rbank, t_idx'(r_j - t_len'(1))};
    assign w_cand        = t_rev'(i_price_rdata) + w_rev_rdata;
    assign w_cut_fix     = (w_cut_rdata == '0 || w_cut_rdata > r_rest) ? r_rest : w_cut_rdata;

    assign o_stat.pop  = (r_state == S_IDLE) && i_head.not_empty;
    assign o_stat.done = (r_state == S_EMIT) && o_out.ready && r_last;

    assign o_out.valid        = r_out_valid;
    assign o_out.piece_length = t_out_len'(r_piece);
    assign o_out.best_revenue = t_out_rev'(r_total);
    assign o_out.last_piece   = r_last;

    always_ff @(posedge i_clk) begin
        // Compare stage: one candidate cut per cycle, strict greater keeps the smaller cut.
        if (r_dv) begin
            if (r_dj == t_len'(1) || w_cand > r_best) begin
                r_best <= w_cand;
                r_cut  <= r_dj;
            end
        end
        r_dj <= r_j;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_rbank     <= '0;
        end else begin
            r_dv <= (r_state == S_ISSUE);
            case (r_state)
                S_IDLE: begin
                    if (i_head.not_empty) begin
                        r_n     <= i_head.len;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_i     <= t_len'(1);
                    r_j     <= t_len'(1);
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (r_j == r_i) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_j <= r_j + t_len'(1);
                    end
                end
                S_WAIT: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (r_i == r_n) begin
                        r_total <= r_best;
                        r_rest  <= r_n;
                        r_state <= S_TREAD;
                    end else begin
                        r_i     <= r_i + t_len'(1);
                        r_j     <= t_len'(1);
                        r_state <= S_ISSUE;
                    end
                end
                S_TREAD: begin
                    r_state <= S_TOUT;
                end
                S_TOUT: begin
                    r_piece     <= w_cut_fix;
                    r_last      <= (w_cut_fix == r_rest);
                    r_rest      <= r_rest - w_cut_fix;
                    r_out_valid <= 1'b1;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_rbank <= r_rbank + t_bank'(1);
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_TREAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cut_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> (r_cut != '0 && r_cut <= r_i))
        else $error("first cut outside one to current length");

    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_EMIT))
        else $error("result shown outside the emit state");
endmodule
